@@ hdl/srsbd_pkg.sv @@
`default_nettype none

package srsbd_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int YEAR_BITS_DEF   = 14;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int RECNO_W = 6;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               last;
    } t_in_word;

    typedef struct packed {
        logic [RECNO_W-1:0] record_number;
        logic               final_res;
        logic               overflow;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_HOLD
    } t_state;

endpackage

`default_nettype wire

@@ hdl/stable_record_sort_by_date_top.sv @@
`default_nettype none
// stable date sort of a record set
// input channel (i_in_valid / o_in_stall / i_in_data): one word per record,
//   year, month and day as key, last marking the end of the set
// records are numbered by arrival from 0 and inserted into a sorted store,
//   equal dates keep arrival order; records past MAX_RECORDS are dropped
// insertion walks down the store with one comparator over one read port and
//   one write port: each step reads the entry below, compares it and either
//   shifts it up one slot or places the record; at the bottom of the store the
//   record is placed without a read; o_in_stall stays high meanwhile
// after the last record the store is read out in sorted order on the output
//   channel (o_out_valid / i_out_stall / o_out_data), each word read, loaded
//   and held while stalled; final_res marks the last word, overflow is set on
//   every word of a set that lost records
// a stalled output word holds and the block takes no new record until the
//   whole set has been delivered, after which it is empty for the next set
// reset (i_rst_n low, synchronous) empties the store, clears the overflow
//   mark and drops any word in flight; no clearing pass is needed

module stable_record_sort_by_date_top #(
    parameter int MAX_RECORDS = srsbd_pkg::MAX_RECORDS_DEF,
    parameter int YEAR_BITS   = srsbd_pkg::YEAR_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire srsbd_pkg::t_in_word i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output srsbd_pkg::t_out_word     o_out_data
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int EW = YEAR_BITS + srsbd_pkg::MONTH_W + srsbd_pkg::DAY_W + AW;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    srsbd_seq #(
        .MAX_RECORDS (MAX_RECORDS),
        .YEAR_BITS   (YEAR_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    srsbd_store #(
        .DEPTH (MAX_RECORDS),
        .WIDTH (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

@@ hdl/srsbd_store.sv @@
`default_nettype none

module srsbd_store #(
    parameter int DEPTH = srsbd_pkg::MAX_RECORDS_DEF,
    parameter int WIDTH = srsbd_pkg::YEAR_BITS_DEF + 9 + $clog2(srsbd_pkg::MAX_RECORDS_DEF)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/srsbd_seq.sv @@
`default_nettype none

module srsbd_seq #(
    parameter int MAX_RECORDS = srsbd_pkg::MAX_RECORDS_DEF,
    parameter int YEAR_BITS   = srsbd_pkg::YEAR_BITS_DEF,
    localparam int AW = $clog2(MAX_RECORDS),
    localparam int CW = $clog2(MAX_RECORDS + 1),
    localparam int KW = YEAR_BITS + srsbd_pkg::MONTH_W + srsbd_pkg::DAY_W,
    localparam int EW = KW + AW
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire srsbd_pkg::t_in_word   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output srsbd_pkg::t_out_word       o_out_data,
    output logic                       o_mem_we,
    output logic [AW-1:0]              o_mem_waddr,
    output logic [EW-1:0]              o_mem_wdata,
    output logic                       o_mem_re,
    output logic [AW-1:0]              o_mem_raddr,
    input  wire logic [EW-1:0]         i_mem_rdata
);

    srsbd_pkg::t_state    r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_dropped, n_dropped;
    logic                 r_out_valid, n_out_valid;
    logic [AW-1:0]        r_pos, n_pos;
    logic [AW-1:0]        r_idx, n_idx;
    logic [KW-1:0]        r_key, n_key;
    logic [AW-1:0]        r_num, n_num;
    logic                 r_last, n_last;
    srsbd_pkg::t_out_word r_out, n_out;

    logic [31:0]   w_year32;
    logic [KW-1:0] w_key;
    logic          w_full;

    assign w_year32 = 32'(i_in_data.year);
    assign w_key    = {w_year32[YEAR_BITS-1:0], i_in_data.month, i_in_data.day};
    assign w_full   = (r_count == CW'(MAX_RECORDS));

    assign o_in_stall  = (r_state != srsbd_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srsbd_pkg::S_IDLE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_idx  <= n_idx;
        r_key  <= n_key;
        r_num  <= n_num;
        r_last <= n_last;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_key       = r_key;
        n_num       = r_num;
        n_last      = r_last;
        n_out       = r_out;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pos;
        o_mem_wdata = {r_key, r_num};
        o_mem_re    = 1'b0;
        o_mem_raddr = r_pos - AW'(1);

        case (r_state)
            srsbd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                        if (i_in_data.last) begin
                            n_idx   = '0;
                            n_state = srsbd_pkg::S_OUT_RD;
                        end
                    end else begin
                        n_key   = w_key;
                        n_num   = r_count[AW-1:0];
                        n_pos   = r_count[AW-1:0];
                        n_last  = i_in_data.last;
                        n_state = srsbd_pkg::S_SCAN_RD;
                    end
                end
            end
            srsbd_pkg::S_SCAN_RD: begin
                if (r_pos == '0) begin
                    o_mem_we = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_idx    = '0;
                    n_state  = r_last ? srsbd_pkg::S_OUT_RD : srsbd_pkg::S_IDLE;
                end else begin
                    o_mem_re = 1'b1;
                    n_state  = srsbd_pkg::S_SCAN_CMP;
                end
            end
            srsbd_pkg::S_SCAN_CMP: begin
                o_mem_we = 1'b1;
                if (r_key < i_mem_rdata[EW-1:AW]) begin
                    // shift the stored entry up one slot
                    o_mem_wdata = i_mem_rdata;
                    n_pos       = r_pos - AW'(1);
                    n_state     = srsbd_pkg::S_SCAN_RD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_idx   = '0;
                    n_state = r_last ? srsbd_pkg::S_OUT_RD : srsbd_pkg::S_IDLE;
                end
            end
            srsbd_pkg::S_OUT_RD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = r_idx;
                n_state     = srsbd_pkg::S_OUT_LD;
            end
            srsbd_pkg::S_OUT_LD: begin
                n_out.record_number = srsbd_pkg::RECNO_W'(i_mem_rdata[AW-1:0]);
                n_out.final_res     = ((CW'(r_idx) + CW'(1)) == r_count);
                n_out.overflow      = r_dropped;
                n_out_valid         = 1'b1;
                n_state             = srsbd_pkg::S_OUT_HOLD;
            end
            srsbd_pkg::S_OUT_HOLD: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out.final_res) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = srsbd_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = srsbd_pkg::S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = srsbd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/srsbd_checker.sv @@
`default_nettype none

module srsbd_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_stall,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_stall,
    input wire srsbd_pkg::t_out_word i_out_data
);

    logic w_out_acc;

    assign w_out_acc = i_out_valid && !i_out_stall;

    // no output word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output word changed");

    // no record taken while a result word is pending
    a_busy_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_in_stall)
        else $error("input open while output pending");

    // a set ends with its final word, then the output is quiet and the input is open
    a_final_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && i_out_data.final_res |=> !i_out_valid && !i_in_stall)
        else $error("activity after final word");

    // overflow mark is the same on consecutive words of one set
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !i_out_data.final_res ##3 i_out_valid
            |-> i_out_data.overflow == $past(i_out_data.overflow, 3))
        else $error("overflow mark changed within a set");

endmodule

bind stable_record_sort_by_date_top srsbd_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire

@@ test/date_sort_checker.sv @@
module date_sort_checker #(
    parameter int MAX_RECORDS = srsbd_pkg::MAX_RECORDS_DEF,
    parameter int YEAR_BITS   = srsbd_pkg::YEAR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  srsbd_pkg::t_in_word  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  srsbd_pkg::t_out_word i_out_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int KEY_W = YEAR_BITS + srsbd_pkg::MONTH_W + srsbd_pkg::DAY_W;

    logic [KEY_W-1:0]              date_keys    [MAX_RECORDS];
    logic [srsbd_pkg::RECNO_W-1:0] arrival_nums [MAX_RECORDS];
    int                            stored_count;
    bit                            set_overflowed;
    srsbd_pkg::t_out_word          expected_order [$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        stored_count   = 0;
        set_overflowed = 1'b0;
    end

    // stable insertion by date; the last record of a set releases the sorted order
    task automatic insert_and_emit(input srsbd_pkg::t_in_word w);
        logic [KEY_W-1:0]     key;
        int                   pos;
        srsbd_pkg::t_out_word res;
        key = {w.year[YEAR_BITS-1:0], w.month, w.day};
        if (stored_count >= MAX_RECORDS) begin
            set_overflowed = 1'b1;
        end else begin
            pos = stored_count;
            while (pos > 0 && key < date_keys[pos-1]) begin
                date_keys[pos]    = date_keys[pos-1];
                arrival_nums[pos] = arrival_nums[pos-1];
                pos--;
            end
            date_keys[pos]    = key;
            arrival_nums[pos] = stored_count[srsbd_pkg::RECNO_W-1:0];
            stored_count++;
        end
        if (w.last) begin
            for (int i = 0; i < stored_count; i++) begin
                res.record_number = arrival_nums[i];
                res.final_res     = (i == stored_count - 1);
                res.overflow      = set_overflowed;
                expected_order.push_back(res);
            end
            stored_count   = 0;
            set_overflowed = 1'b0;
        end
    endtask

    task automatic check_word(input srsbd_pkg::t_out_word got);
        srsbd_pkg::t_out_word want;
        if (expected_order.size() == 0) begin
            $display("%0t: unexpected word, expected none, got record_number %0d final %0d ovf %0d",
                     $time, got.record_number, got.final_res, got.overflow);
            o_fail_count++;
        end else begin
            want = expected_order.pop_front();
            if (got.record_number !== want.record_number) begin
                $display("%0t: record_number expected %0d, got %0d",
                         $time, want.record_number, got.record_number);
                o_fail_count++;
            end
            if (got.final_res !== want.final_res) begin
                $display("%0t: final_res expected %0d, got %0d",
                         $time, want.final_res, got.final_res);
                o_fail_count++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %0d, got %0d",
                         $time, want.overflow, got.overflow);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_count   = 0;
            set_overflowed = 1'b0;
            expected_order.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_word(i_out_data);
            end
            if (i_in_valid && !i_in_stall) begin
                insert_and_emit(i_in_data);
            end
        end
        o_pending = expected_order.size();
    end

endmodule

@@ test/tb_stable_record_sort_by_date_top.sv @@
module tb_stable_record_sort_by_date_top;

    localparam int HOLD_CYCLES = 500;
    localparam int YEAR_W      = srsbd_pkg::YEAR_W;
    localparam int MONTH_W     = srsbd_pkg::MONTH_W;
    localparam int DAY_W       = srsbd_pkg::DAY_W;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    srsbd_pkg::t_in_word  in_data;
    logic                 out_valid;
    logic                 out_stall;
    srsbd_pkg::t_out_word out_data;

    int fail_count;
    int pending;
    int sent;
    int sender_idle_pct;
    int receiver_idle_pct;
    bit hold_req;

    stable_record_sort_by_date_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    date_sort_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic srsbd_pkg::t_in_word make_word(input int y, input int m, input int d,
                                                      input bit l);
        srsbd_pkg::t_in_word w;
        w.year  = YEAR_W'(y);
        w.month = MONTH_W'(m);
        w.day   = DAY_W'(d);
        w.last  = l;
        return w;
    endfunction

    task automatic send_word(input srsbd_pkg::t_in_word w);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // random dates, narrow pools for most years and months and half the days so equal dates show up
    task automatic send_set(input int size);
        srsbd_pkg::t_in_word w;
        for (int k = 0; k < size; k++) begin
            if ($urandom_range(3) == 0) begin
                w.year = YEAR_W'($urandom_range((1 << YEAR_W) - 1));
            end else begin
                w.year = YEAR_W'(2000 + $urandom_range(2));
            end
            if ($urandom_range(3) == 0) begin
                w.month = MONTH_W'($urandom_range(15));
            end else begin
                w.month = MONTH_W'($urandom_range(12, 1));
            end
            if ($urandom_range(1) == 0) begin
                w.day = DAY_W'($urandom_range(31));
            end else begin
                w.day = DAY_W'($urandom_range(3, 1));
            end
            w.last = (k == size - 1);
            send_word(w);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    // receiver side
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int quota;
        int size;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        in_data           = '0;
        sent              = 0;
        hold_req          = 1'b0;
        sender_idle_pct   = 19;
        receiver_idle_pct = 67;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single-record sets
        send_word(make_word(0, 0, 0, 1));
        send_word(make_word(16383, 15, 31, 1));
        // equal dates keep arrival order
        send_word(make_word(9999, 12, 31, 0));
        send_word(make_word(0, 0, 0, 0));
        send_word(make_word(9999, 12, 31, 0));
        send_word(make_word(0, 0, 0, 0));
        send_word(make_word(5000, 6, 15, 0));
        send_word(make_word(9999, 12, 31, 1));
        // out-of-range month and day codes, then a set of two equal dates
        send_word(make_word(2000, 15, 0, 0));
        send_word(make_word(2000, 0, 31, 0));
        send_word(make_word(2000, 1, 1, 0));
        send_word(make_word(2000, 0, 0, 0));
        send_word(make_word(2000, 12, 31, 0));
        send_word(make_word(2000, 0, 31, 1));
        send_word(make_word(1999, 7, 7, 0));
        send_word(make_word(1999, 7, 7, 1));
        // descending dates, each insertion walks the whole store
        send_word(make_word(16383, 15, 31, 0));
        send_word(make_word(8192, 8, 16, 0));
        send_word(make_word(4096, 4, 8, 0));
        send_word(make_word(1, 1, 1, 0));
        send_word(make_word(0, 0, 0, 1));
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct   = 19;
                    receiver_idle_pct = 67;
                end
                1: begin
                    sender_idle_pct   = 67;
                    receiver_idle_pct = 19;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                    hold_req          = 1'b1;
                end
            endcase
            quota = sent + 40;
            while (sent < quota) begin
                if ($urandom_range(7) == 0) begin
                    size = $urandom_range(40, 20);
                end else begin
                    size = $urandom_range(10, 1);
                end
                send_set(size);
            end
            // full store, last record dropped, two records dropped
            send_set(64 + ph);
            drain();
        end

        repeat (400) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
